[hw/rtl/rbi_pkg.sv]
// ============================================================================
// rbi_pkg
// Types, constants and helper functions shared by the ray/box test pipeline.
// ============================================================================
package rbi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W         = 32;
    // Magnitude of (plane - origin) scaled by 2^FRAC_BITS.
    localparam int NUM_W      = W + 1 + FRAC_BITS;
    localparam int DIV_STAGES = (NUM_W + 1) / 2;
    localparam int NUM_PAD    = 2 * DIV_STAGES;
    localparam int PAD_Z      = NUM_PAD - NUM_W;

    localparam logic signed [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};
    // -1.0 in fixed point.
    localparam logic signed [W-1:0] T_NONE = -(W'(1) <<< FRAC_BITS);

    typedef logic [2:0][W-1:0] t_vec3;

    typedef struct packed {
        logic [W-1:0] box_min_x;
        logic [W-1:0] box_min_y;
        logic [W-1:0] box_min_z;
        logic [W-1:0] box_max_x;
        logic [W-1:0] box_max_y;
        logic [W-1:0] box_max_z;
        logic [W-1:0] ray_org_x;
        logic [W-1:0] ray_org_y;
        logic [W-1:0] ray_org_z;
        logic [W-1:0] ray_dir_x;
        logic [W-1:0] ray_dir_y;
        logic [W-1:0] ray_dir_z;
    } t_in_beat;

    typedef struct packed {
        logic         is_hit;
        logic [W-1:0] hit_x;
        logic [W-1:0] hit_y;
        logic [W-1:0] hit_z;
    } t_out_beat;

    // Ray context carried alongside the arithmetic.
    typedef struct packed {
        t_vec3      lo;
        t_vec3      hi;
        t_vec3      org;
        t_vec3      dir;
        t_vec3      plane;
        logic       in_box;
        logic [2:0] div_ok;
        logic [2:0] q_neg;
    } t_ctx;

    typedef struct packed {
        logic [W:0]         rem;
        logic [NUM_PAD-1:0] num;
        logic [NUM_PAD-1:0] quo;
        logic [W-1:0]       den;
    } t_lane;

    // One restoring division step: shift in a numerator bit, subtract if it fits.
    function automatic t_lane div_step(input t_lane l);
        t_lane      r;
        logic [W:0] sh;
        sh = {l.rem[W-1:0], l.num[NUM_PAD-1]};
        r  = l;
        r.num = {l.num[NUM_PAD-2:0], 1'b0};
        if (sh >= {1'b0, l.den}) begin
            r.rem = sh - {1'b0, l.den};
            r.quo = {l.quo[NUM_PAD-2:0], 1'b1};
        end else begin
            r.rem = sh;
            r.quo = {l.quo[NUM_PAD-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [W-1:0] sat64(input logic signed [2*W-1:0] v);
        logic [W-1:0] r;
        if (v > 64'(S_MAX)) begin
            r = S_MAX;
        end else if (v < 64'(S_MIN)) begin
            r = S_MIN;
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    function automatic logic [W-1:0] sat33(input logic signed [W:0] v);
        logic [W-1:0] r;
        if (v[W] != v[W-1]) begin
            r = v[W] ? S_MIN : S_MAX;
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/rbi_classify.sv]
// ============================================================================
// rbi_classify
// Slab classification and divider operand setup, one register stage.
// ============================================================================
module rbi_classify (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  rbi_pkg::t_in_beat i_beat,
    output logic              o_valid,
    output rbi_pkg::t_ctx     o_ctx,
    output rbi_pkg::t_lane    o_lane [3]
);
    import rbi_pkg::*;

    logic   r_valid;
    t_ctx   r_ctx,  n_ctx;
    t_lane  r_lane [3];
    t_lane  n_lane [3];

    always_comb begin
        logic signed [W:0] diff;
        logic [W:0]        mag;
        logic [W-1:0]      dmag;
        n_ctx.lo  = {i_beat.box_min_z, i_beat.box_min_y, i_beat.box_min_x};
        n_ctx.hi  = {i_beat.box_max_z, i_beat.box_max_y, i_beat.box_max_x};
        n_ctx.org = {i_beat.ray_org_z, i_beat.ray_org_y, i_beat.ray_org_x};
        n_ctx.dir = {i_beat.ray_dir_z, i_beat.ray_dir_y, i_beat.ray_dir_x};
        n_ctx.in_box = 1'b1;
        for (int i = 0; i < 3; i++) begin
            n_ctx.plane[i] = '0;
            n_ctx.div_ok[i] = 1'b0;
            // Below min is tested first; an inverted box is left below min, else right.
            if ($signed(n_ctx.org[i]) < $signed(n_ctx.lo[i])) begin
                n_ctx.plane[i]  = n_ctx.lo[i];
                n_ctx.div_ok[i] = |n_ctx.dir[i];
                n_ctx.in_box    = 1'b0;
            end else if ($signed(n_ctx.org[i]) > $signed(n_ctx.hi[i])) begin
                n_ctx.plane[i]  = n_ctx.hi[i];
                n_ctx.div_ok[i] = |n_ctx.dir[i];
                n_ctx.in_box    = 1'b0;
            end
            diff = $signed({n_ctx.plane[i][W-1], n_ctx.plane[i]})
                 - $signed({n_ctx.org[i][W-1], n_ctx.org[i]});
            mag  = diff[W] ? (W+1)'(-diff) : diff;
            dmag = n_ctx.dir[i][W-1] ? W'(-$signed(n_ctx.dir[i])) : n_ctx.dir[i];
            n_ctx.q_neg[i] = diff[W] ^ n_ctx.dir[i][W-1];
            n_lane[i].rem = '0;
            n_lane[i].quo = '0;
            n_lane[i].num = {{PAD_Z{1'b0}}, mag, {FRAC_BITS{1'b0}}};
            n_lane[i].den = n_ctx.div_ok[i] ? dmag : W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctx <= n_ctx;
            for (int i = 0; i < 3; i++) begin
                r_lane[i] <= n_lane[i];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;
    assign o_lane  = r_lane;

endmodule

[hw/rtl/rbi_div_pipe.sv]
// ============================================================================
// rbi_div_pipe
// Pipelined restoring divider, two quotient bits per stage on three axes.
// ============================================================================
module rbi_div_pipe (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  rbi_pkg::t_ctx  i_ctx,
    input  rbi_pkg::t_lane i_lane [3],
    output logic           o_valid,
    output rbi_pkg::t_ctx  o_ctx,
    output rbi_pkg::t_lane o_lane [3]
);
    import rbi_pkg::*;

    logic  r_valid [DIV_STAGES];
    t_ctx  r_ctx   [DIV_STAGES];
    t_lane r_lane  [DIV_STAGES][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else if (i_adv) begin
            r_valid[0] <= i_valid;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_valid[s] <= r_valid[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctx[0] <= i_ctx;
            for (int i = 0; i < 3; i++) begin
                r_lane[0][i] <= div_step(div_step(i_lane[i]));
            end
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_ctx[s] <= r_ctx[s-1];
                for (int i = 0; i < 3; i++) begin
                    r_lane[s][i] <= div_step(div_step(r_lane[s-1][i]));
                end
            end
        end
    end

    assign o_valid = r_valid[DIV_STAGES-1];
    assign o_ctx   = r_ctx[DIV_STAGES-1];
    assign o_lane  = r_lane[DIV_STAGES-1];

endmodule

[hw/rtl/rbi_select.sv]
// ============================================================================
// rbi_select
// Signs and saturates the distances, then picks the largest one.
// ============================================================================
module rbi_select (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  rbi_pkg::t_ctx                 i_ctx,
    input  rbi_pkg::t_lane                i_lane [3],
    output logic                          o_valid,
    output rbi_pkg::t_ctx                 o_ctx,
    output logic signed [rbi_pkg::W-1:0]  o_t,
    output logic [1:0]                    o_best
);
    import rbi_pkg::*;

    logic                r_valid;
    t_ctx                r_ctx;
    logic signed [W-1:0] r_t, n_t;
    logic [1:0]          r_best, n_best;
    logic signed [W-1:0] t [3];

    always_comb begin
        logic [NUM_PAD-1:0] q;
        for (int i = 0; i < 3; i++) begin
            q = i_lane[i].quo;
            if (!i_ctx.div_ok[i]) begin
                t[i] = T_NONE;
            end else if (i_ctx.q_neg[i]) begin
                if ((|q[NUM_PAD-1:W]) || (q[W-1] && (|q[W-2:0]))) begin
                    t[i] = S_MIN;
                end else begin
                    t[i] = W'(-$signed(q[W-1:0]));
                end
            end else begin
                t[i] = (|q[NUM_PAD-1:W-1]) ? S_MAX : $signed(q[W-1:0]);
            end
        end
        // The lowest axis wins a tie.
        n_best = 2'd0;
        n_t    = t[0];
        if (n_t < t[1]) begin
            n_best = 2'd1;
            n_t    = t[1];
        end
        if (n_t < t[2]) begin
            n_best = 2'd2;
            n_t    = t[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctx  <= i_ctx;
            r_t    <= n_t;
            r_best <= n_best;
        end
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;
    assign o_t     = r_t;
    assign o_best  = r_best;

endmodule

[hw/rtl/rbi_hit.sv]
// ============================================================================
// rbi_hit
// Forms the hit point on the other two axes and checks it against the box; an origin inside the box is the hit.
// ============================================================================
module rbi_hit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_valid,
    input  rbi_pkg::t_ctx                i_ctx,
    input  logic signed [rbi_pkg::W-1:0] i_t,
    input  logic [1:0]                   i_best,
    output logic                         o_valid,
    output rbi_pkg::t_out_beat           o_beat
);
    import rbi_pkg::*;

    // Stage 1: products.
    logic                  r_v1;
    t_ctx                  r_ctx1;
    logic                  r_neg1;
    logic [1:0]            r_best1;
    logic signed [2*W-1:0] r_prod [3];
    // Stage 2: scaled and offset coordinates.
    logic                  r_v2;
    t_ctx                  r_ctx2;
    logic                  r_neg2;
    logic [1:0]            r_best2;
    t_vec3                 r_pt, n_pt;
    // Stage 3: result register.
    logic                  r_v3;
    t_out_beat             r_beat, n_beat;

    always_comb begin
        logic signed [2*W-1:0] sh;
        logic signed [W:0]     sum;
        logic [W-1:0]          p;
        for (int i = 0; i < 3; i++) begin
            sh   = r_prod[i] >>> FRAC_BITS;
            p    = sat64(sh);
            sum  = $signed({r_ctx1.org[i][W-1], r_ctx1.org[i]}) + $signed({p[W-1], p});
            n_pt[i] = sat33(sum);
        end
    end

    always_comb begin
        logic ok;
        t_vec3 h;
        ok = !r_neg2;
        for (int i = 0; i < 3; i++) begin
            if (i[1:0] == r_best2) begin
                h[i] = r_ctx2.plane[i];
            end else begin
                h[i] = r_pt[i];
                if ($signed(r_pt[i]) < $signed(r_ctx2.lo[i])
                        || $signed(r_pt[i]) > $signed(r_ctx2.hi[i])) begin
                    ok = 1'b0;
                end
            end
        end
        if (r_ctx2.in_box) begin
            n_beat = '{is_hit: 1'b1, hit_x: r_ctx2.org[0], hit_y: r_ctx2.org[1],
                       hit_z: r_ctx2.org[2]};
        end else if (ok) begin
            n_beat = '{is_hit: 1'b1, hit_x: h[0], hit_y: h[1], hit_z: h[2]};
        end else begin
            n_beat = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctx1  <= i_ctx;
            r_neg1  <= i_t[W-1];
            r_best1 <= i_best;
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= i_t * $signed(i_ctx.dir[i]);
            end
            r_ctx2  <= r_ctx1;
            r_neg2  <= r_neg1;
            r_best2 <= r_best1;
            r_pt    <= n_pt;
            r_beat  <= n_beat;
        end
    end

    assign o_valid = r_v3;
    assign o_beat  = r_beat;

    a_inside_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && r_v2 && r_ctx2.in_box |=> o_valid && o_beat.is_hit)
        else $error("inside origin not reported as hit");

endmodule

[hw/rtl/ray_box_intersect.sv]
// ============================================================================
// ray_box_intersect
// Ray versus axis-aligned box test in signed Q16.16, fully pipelined.
// ============================================================================
// One input beat carries a box (min and max corners) and a ray (origin and
// direction); one output beat carries is_hit and the hit point, with zero
// coordinates on a miss. Both channels use valid/stall: a beat moves on a
// clock edge where valid is high and stall is low.
// The pipeline has one classification stage, 25 divider stages (two
// quotient bits each, three axes side by side), one selection stage and
// three stages for the products, the scaling and the box check.
// Throughput is one beat per cycle while the output is not stalled; every stage holds one independent test.
// The whole pipeline advances together whenever the output register is
// empty or its beat is taken. When the receiver stalls with a beat waiting,
// all stages hold and o_stall rises in the same cycle, so nothing is lost.
// Reset (synchronous, active low) clears every stage's valid bit; the block
// accepts beats as soon as reset is released.
// ============================================================================
module ray_box_intersect (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  rbi_pkg::t_in_beat  i_beat,
    output logic               o_valid,
    input  logic               i_stall,
    output rbi_pkg::t_out_beat o_beat
);
    import rbi_pkg::*;

    logic                adv;
    logic                cls_valid, div_valid, sel_valid;
    t_ctx                cls_ctx, div_ctx, sel_ctx;
    t_lane               cls_lane [3];
    t_lane               div_lane [3];
    logic signed [W-1:0] sel_t;
    logic [1:0]          sel_best;

    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;

    rbi_classify u_classify (
        .i_clk, .i_rst_n, .i_adv(adv), .i_valid, .i_beat,
        .o_valid(cls_valid), .o_ctx(cls_ctx), .o_lane(cls_lane)
    );

    rbi_div_pipe u_div (
        .i_clk, .i_rst_n, .i_adv(adv), .i_valid(cls_valid), .i_ctx(cls_ctx),
        .i_lane(cls_lane), .o_valid(div_valid), .o_ctx(div_ctx), .o_lane(div_lane)
    );

    rbi_select u_select (
        .i_clk, .i_rst_n, .i_adv(adv), .i_valid(div_valid), .i_ctx(div_ctx),
        .i_lane(div_lane), .o_valid(sel_valid), .o_ctx(sel_ctx), .o_t(sel_t),
        .o_best(sel_best)
    );

    rbi_hit u_hit (
        .i_clk, .i_rst_n, .i_adv(adv), .i_valid(sel_valid), .i_ctx(sel_ctx),
        .i_t(sel_t), .i_best(sel_best), .o_valid, .o_beat
    );

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_beat.is_hit |-> o_beat.hit_x == '0 && o_beat.hit_y == '0
                                      && o_beat.hit_z == '0)
        else $error("miss beat with nonzero coordinates");

    a_stall_only_full: assert property (@(posedge i_clk)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output can move");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

endmodule

[bench/ray_box_checker.sv]
// ----------------------------------------------------------------------------
// ray_box_checker
// Watches both channels of the ray/box test, computes the expected hit for
// every accepted input beat and compares each output beat against it.
// ----------------------------------------------------------------------------
module ray_box_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  rbi_pkg::t_in_beat  i_beat,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  rbi_pkg::t_out_beat i_out_beat,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_hits,
    output int                 o_misses
);
    timeunit 1ns;
    timeprecision 1ps;

    import rbi_pkg::*;

    typedef enum int {AX_LEFT, AX_RIGHT, AX_INSIDE} t_side;

    t_out_beat hit_queue[$];

    function automatic longint clamp32(input longint v);
        longint r;
        r = v;
        if (v > 64'sd2147483647) r = 64'sd2147483647;
        if (v < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    function automatic t_out_beat predict_hit(input t_in_beat b);
        longint    lo[3], hi[3], org[3], dir[3], plane[3], t_cand[3], pt[3];
        longint    prod, num;
        t_side     side[3];
        logic      in_box;
        int        best;
        t_out_beat r;
        lo[0] = longint'($signed(b.box_min_x));
        lo[1] = longint'($signed(b.box_min_y));
        lo[2] = longint'($signed(b.box_min_z));
        hi[0] = longint'($signed(b.box_max_x));
        hi[1] = longint'($signed(b.box_max_y));
        hi[2] = longint'($signed(b.box_max_z));
        org[0] = longint'($signed(b.ray_org_x));
        org[1] = longint'($signed(b.ray_org_y));
        org[2] = longint'($signed(b.ray_org_z));
        dir[0] = longint'($signed(b.ray_dir_x));
        dir[1] = longint'($signed(b.ray_dir_y));
        dir[2] = longint'($signed(b.ray_dir_z));
        r = '0;
        in_box = 1'b1;
        for (int i = 0; i < 3; i++) begin
            plane[i] = 0;
            if (org[i] < lo[i]) begin
                side[i] = AX_LEFT;
                plane[i] = lo[i];
                in_box = 1'b0;
            end else if (org[i] > hi[i]) begin
                side[i] = AX_RIGHT;
                plane[i] = hi[i];
                in_box = 1'b0;
            end else begin
                side[i] = AX_INSIDE;
            end
        end
        if (in_box) begin
            r.is_hit = 1'b1;
            r.hit_x = org[0][31:0];
            r.hit_y = org[1][31:0];
            r.hit_z = org[2][31:0];
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            if (side[i] != AX_INSIDE && dir[i] != 0) begin
                num = (plane[i] - org[i]) * (64'sd1 <<< FRAC_BITS);
                t_cand[i] = clamp32(num / dir[i]);
            end else begin
                t_cand[i] = -(64'sd1 <<< FRAC_BITS);
            end
        end
        best = 0;
        for (int i = 1; i < 3; i++)
            if (t_cand[best] < t_cand[i]) best = i;
        if (t_cand[best] < 0) return r;
        for (int i = 0; i < 3; i++) begin
            if (i != best) begin
                // Arithmetic shift gives the floor that the scaling needs.
                prod = clamp32((t_cand[best] * dir[i]) >>> FRAC_BITS);
                pt[i] = clamp32(org[i] + prod);
                if (pt[i] < lo[i] || pt[i] > hi[i]) return r;
            end else begin
                pt[i] = plane[i];
            end
        end
        r.is_hit = 1'b1;
        r.hit_x = pt[0][31:0];
        r.hit_y = pt[1][31:0];
        r.hit_z = pt[2][31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            o_errors <= 0;
            o_hits <= 0;
            o_misses <= 0;
        end else begin
            if (i_valid && !i_stall_in) begin
                hit_queue.push_back(predict_hit(i_beat));
            end
            if (i_out_valid && !i_out_stall) begin
                if (hit_queue.size() == 0) begin
                    $display("%0t: unexpected beat, actual %h", $time, i_out_beat);
                    o_errors <= o_errors + 1;
                end else begin
                    want = hit_queue.pop_front();
                    if (want.is_hit) o_hits <= o_hits + 1;
                    else o_misses <= o_misses + 1;
                    if (want.is_hit !== i_out_beat.is_hit || want.hit_x !== i_out_beat.hit_x
                        || want.hit_y !== i_out_beat.hit_y
                        || want.hit_z !== i_out_beat.hit_z) begin
                        $display("%0t: mismatch, expected hit=%b %h %h %h, actual hit=%b %h %h %h",
                                 $time, want.is_hit, want.hit_x, want.hit_y, want.hit_z,
                                 i_out_beat.is_hit, i_out_beat.hit_x, i_out_beat.hit_y,
                                 i_out_beat.hit_z);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

    assign o_pending = hit_queue.size();

endmodule

[bench/ray_box_intersect_tb.sv]
// ----------------------------------------------------------------------------
// ray_box_intersect_tb
// Drives directed and random ray/box tests into the pipeline with random
// gaps and output stalls; the checker predicts and compares every beat.
// ----------------------------------------------------------------------------
module ray_box_intersect_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rbi_pkg::*;

    localparam int N_RANDOM = 1000;
    localparam int LATENCY  = 30;
    localparam int IDLE_LIMIT = 2000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_beat  i_beat;
    logic      o_valid;
    logic      i_stall;
    t_out_beat o_beat;
    int        n_errors, n_pending, n_hits, n_misses;
    int        idle_cycles;
    int        n_sent;

    ray_box_intersect uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_beat  (i_beat),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_beat  (o_beat)
    );

    ray_box_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_stall_in  (o_stall),
        .i_beat      (i_beat),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_beat  (o_beat),
        .o_errors    (n_errors),
        .o_pending   (n_pending),
        .o_hits      (n_hits),
        .o_misses    (n_misses)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Before each output beat the receiver holds stall for a random wait.
    initial begin
        int gap;
        i_stall = 1'b0;
        forever begin
            gap = $urandom_range(0, 5);
            @(negedge i_clk);
            if (gap != 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // Watchdog on cycles with no traffic on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > IDLE_LIMIT) begin
            $display("ray_box_intersect_tb: errors");
            $finish;
        end
    end

    function automatic logic [31:0] pick_edge();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = 32'h0000_0000;
            3: v = 32'hFFFF_FFFF;
            4: v = 32'h0001_0000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Builds a box and ray in a small range so that hits are common; mode 2 uses edge values, mode 3 random fields.
    function automatic t_in_beat make_ray(input int mode);
        t_in_beat b;
        int lo, hi;
        logic [31:0] f[12];
        for (int a = 0; a < 3; a++) begin
            lo = $signed($urandom_range(0, 40 << 16)) - (20 << 16);
            hi = lo + $urandom_range(0, 20 << 16);
            f[a] = lo;
            f[3 + a] = hi;
            f[6 + a] = $signed($urandom_range(0, 120 << 16)) - (60 << 16);
            f[9 + a] = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
            if ($urandom_range(0, 9) == 0) f[9 + a] = 0;
        end
        if (mode == 1) begin
            // Aim the ray at a point inside the box.
            for (int a = 0; a < 3; a++)
                f[9 + a] = ($signed(f[a]) + $signed(f[3 + a])) / 2 - $signed(f[6 + a]);
            for (int a = 0; a < 3; a++) f[9 + a] = $signed(f[9 + a]) >>> $urandom_range(0, 3);
        end else if (mode == 2) begin
            for (int a = 0; a < 12; a++) f[a] = pick_edge();
        end else if (mode == 3) begin
            for (int a = 0; a < 12; a++) f[a] = $urandom;
        end
        b = {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9], f[10], f[11]};
        return b;
    endfunction

    task automatic send_beat(input t_in_beat b);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_beat <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        n_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (n_pending != 0) @(negedge i_clk);
    endtask

    initial begin
        t_in_beat b;
        int wait_cycles;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_beat = '0;
        n_sent = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Origin inside the box.
        b = {32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
             32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
             32'h0000_8000, 32'h0, 32'hFFFF_8000, 32'h0, 32'h0, 32'h0};
        send_beat(b);
        // Plain hit along x from the left, and from the right along z.
        b = {32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
             32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
             32'hFFFB_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0};
        send_beat(b);
        b = {32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
             32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
             32'h0, 32'h0, 32'h0005_0000, 32'h0, 32'h0, 32'hFFFF_0000};
        send_beat(b);
        // Pointing away: negative distance.
        b = {32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
             32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
             32'hFFFB_0000, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0, 32'h0};
        send_beat(b);
        // Zero direction outside the box.
        b = {32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
             32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
             32'hFFFB_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
        send_beat(b);
        // Tie between x and y, lowest axis wins.
        b = {32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
             32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
             32'hFFFD_0000, 32'hFFFD_0000, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0};
        send_beat(b);
        // Off-axis miss.
        b = {32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
             32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
             32'hFFFB_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0004_0000, 32'h0};
        send_beat(b);
        // Inverted box.
        b = {32'h0001_0000, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0, 32'h0,
             32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0};
        send_beat(b);
        // Saturating division and products at the field extremes.
        b = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0001,
             32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 32'h0000_0001};
        send_beat(b);
        b = {32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h0, 32'h0, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000};
        send_beat(b);
        b = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        send_beat(b);
        b = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        send_beat(b);
        for (int k = 0; k < 8; k++) send_beat(make_ray(2));

        // Let the pipeline empty once before the random part.
        drain();

        for (int k = 0; k < N_RANDOM; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: b = make_ray(1);
                5, 6: b = make_ray(0);
                7, 8: b = make_ray(2);
                default: b = make_ray(3);
            endcase
            send_beat(b);
        end
        i_valid <= 1'b0;

        wait_cycles = 0;
        while (n_pending != 0 && wait_cycles < 100000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(negedge i_clk);
        $display("Sent %0d ray/box tests: %0d hits and %0d misses checked,", n_sent,
                 n_hits, n_misses);
        $display("covering inside origins, face hits, ties, saturation and output stalls.");
        if (n_errors == 0 && n_pending == 0) begin
            $display("ray_box_intersect_tb: clean");
        end else begin
            $display("ray_box_intersect_tb: errors");
        end
        $finish;
    end

endmodule
